### design/mopt_pkg.sv
`timescale 1ns / 1ps

package mopt_pkg;

	localparam int unsigned VAL_W       = 17;
	localparam int unsigned STEP_W      = 6;
	localparam int unsigned STACK_DEPTH = 33;
	localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_ADD1   = 2'd0,
		OP_DOUBLE = 2'd1,
		OP_TRIPLE = 2'd2
	} op_t;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		op_t               op;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_WALK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              start;
		logic [SP_W-1:0]   count;
		logic [STEP_W-1:0] steps;
	} emit_cmd_t;

endpackage

### design/mopt_table.sv
`timescale 1ns / 1ps

module mopt_table #(
	parameter int unsigned DEPTH = 65537,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  mopt_pkg::entry_t wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output mopt_pkg::entry_t rdata_a,
	output mopt_pkg::entry_t rdata_b
);
	import mopt_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### design/mopt_stack.sv
`timescale 1ns / 1ps

module mopt_stack (
	input  logic                       clk,
	input  logic                       we,
	input  logic [mopt_pkg::SP_W-1:0]  waddr,
	input  logic [mopt_pkg::VAL_W-1:0] wdata,
	input  logic                       re,
	input  logic [mopt_pkg::SP_W-1:0]  raddr,
	output logic [mopt_pkg::VAL_W-1:0] rdata
);
	import mopt_pkg::*;

	logic [VAL_W-1:0] mem [STACK_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/mopt_emit.sv
`timescale 1ns / 1ps

module mopt_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mopt_pkg::emit_cmd_t         cmd,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [mopt_pkg::STEP_W-1:0] total_steps,
	output logic                        is_last,
	output logic                        busy,
	output logic                        stack_re,
	output logic [mopt_pkg::SP_W-1:0]   stack_raddr
);
	import mopt_pkg::*;

	logic [SP_W-1:0]   remain_q;
	logic              valid_q;
	logic [STEP_W-1:0] cmd_steps_q;
	logic [STEP_W-1:0] steps_q;
	logic              last_q;
	logic              issue;

	// stack is read top-down so values come out ascending
	assign busy        = (remain_q != '0);
	assign issue       = busy && (!valid_q || !out_stall);
	assign stack_re    = issue;
	assign stack_raddr = remain_q - SP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (cmd.start) begin
				remain_q <= cmd.count;
			end else if (issue) begin
				remain_q <= remain_q - SP_W'(1);
			end
			if (issue) begin
				valid_q <= 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload only moves when a new transaction is loaded
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cmd_steps_q <= cmd.steps;
		end
		if (issue) begin
			steps_q <= cmd_steps_q;
			last_q  <= (remain_q == SP_W'(1));
		end
	end

	assign out_valid   = valid_q;
	assign total_steps = steps_q;
	assign is_last     = last_q;

endmodule

### design/mopt_engine.sv
`timescale 1ns / 1ps

module mopt_engine #(
	parameter int unsigned MAX_N = 65536,
	localparam int unsigned AW = $clog2(MAX_N + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [mopt_pkg::VAL_W-1:0] target,
	output logic                       tbl_we,
	output logic [AW-1:0]              tbl_waddr,
	output mopt_pkg::entry_t           tbl_wdata,
	output logic [AW-1:0]              tbl_raddr_a,
	output logic [AW-1:0]              tbl_raddr_b,
	input  mopt_pkg::entry_t           tbl_rdata_a,
	input  mopt_pkg::entry_t           tbl_rdata_b,
	output logic                       stk_we,
	output logic [mopt_pkg::SP_W-1:0]  stk_waddr,
	output logic [mopt_pkg::VAL_W-1:0] stk_wdata,
	output mopt_pkg::emit_cmd_t        emit_cmd,
	input  logic                       emit_busy
);
	import mopt_pkg::*;

	localparam int unsigned K = AW + 1;
	localparam logic [AW-1:0] RECIP3 = AW'(((64'd1 << K) + 64'd2) / 64'd3);

	state_t            state_q, state_d;

	// next value to be filled and its quotient and remainder by three
	logic [AW:0]       nxt_q;
	logic [AW-1:0]     div3_q;
	logic [1:0]        mod3_q;
	logic [STEP_W-1:0] last_step_q;
	logic [AW-1:0]     n_q;

	logic              vld_s1;
	logic [AW-1:0]     i_s1;
	logic              even_s1;
	logic              tri_s1;
	logic              half1_s1;
	logic              third1_s1;

	logic [AW-1:0]     v_q;
	logic [SP_W-1:0]   depth_q;
	logic [STEP_W-1:0] steps_q;

	logic [31:0]       t32;
	logic [AW-1:0]     n_in;
	logic              need_fill;
	logic              fill_issue;
	logic              accept;
	logic              walk_load;
	logic [AW-1:0]     walk_v;
	logic              walk_done;
	logic [2*AW-1:0]   prod;
	logic [AW-1:0]     third_v;
	logic [AW-1:0]     pred_v;
	logic [STEP_W-1:0] steps_cur;
	logic [STEP_W:0]   best;
	logic [STEP_W:0]   half_inc;
	logic [STEP_W:0]   third_inc;
	op_t               best_op;

	always_comb begin
		t32 = 32'(target);
		if (t32 == 32'd0) begin
			n_in = AW'(1);
		end else if (t32 > 32'(MAX_N)) begin
			n_in = AW'(MAX_N);
		end else begin
			n_in = AW'(t32);
		end
	end

	assign need_fill  = ({1'b0, n_in} >= nxt_q);
	assign fill_issue = (state_q == ST_FILL) && ({1'b0, n_q} >= nxt_q);
	assign accept     = (state_q == ST_IDLE) && in_valid;
	assign in_stall   = (state_q != ST_IDLE);

	// exact division, the value is known to be a multiple of three
	assign prod    = (2*AW)'(v_q) * (2*AW)'(RECIP3);
	assign third_v = AW'(prod[2*AW-1:K]);

	always_comb begin
		case (tbl_rdata_a.op)
			OP_DOUBLE: pred_v = v_q >> 1;
			OP_TRIPLE: pred_v = third_v;
			default:   pred_v = v_q - AW'(1);
		endcase
	end

	assign walk_done = (v_q <= AW'(1)) || (depth_q == SP_W'(STACK_DEPTH - 1));

	// entry one is never stored, it always holds zero steps
	always_comb begin
		if (depth_q == '0) begin
			steps_cur = (v_q <= AW'(1)) ? '0 : tbl_rdata_a.step;
		end else begin
			steps_cur = steps_q;
		end
	end

	always_comb begin
		half_inc  = (half1_s1 ? '0 : {1'b0, tbl_rdata_a.step}) + (STEP_W+1)'(1);
		third_inc = (third1_s1 ? '0 : {1'b0, tbl_rdata_b.step}) + (STEP_W+1)'(1);
		best      = {1'b0, last_step_q} + (STEP_W+1)'(1);
		best_op   = OP_ADD1;
		if (even_s1 && (half_inc < best)) begin
			best    = half_inc;
			best_op = OP_DOUBLE;
		end
		if (tri_s1 && (third_inc < best)) begin
			best    = third_inc;
			best_op = OP_TRIPLE;
		end
	end

	assign tbl_we         = vld_s1;
	assign tbl_waddr      = i_s1;
	assign tbl_wdata.step = best[STEP_W-1:0];
	assign tbl_wdata.op   = best_op;
	assign tbl_raddr_b    = div3_q;

	assign stk_we    = (state_q == ST_WALK);
	assign stk_waddr = depth_q;
	assign stk_wdata = VAL_W'(v_q);

	always_comb begin
		state_d        = state_q;
		tbl_raddr_a    = nxt_q[AW:1];
		walk_load      = 1'b0;
		walk_v         = n_q;
		emit_cmd.start = 1'b0;
		emit_cmd.count = depth_q + SP_W'(1);
		emit_cmd.steps = steps_cur;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (need_fill) begin
						state_d = ST_FILL;
					end else begin
						state_d     = ST_WALK;
						walk_load   = 1'b1;
						walk_v      = n_in;
						tbl_raddr_a = n_in;
					end
				end
			end
			ST_FILL: begin
				if (!fill_issue && !vld_s1) begin
					state_d     = ST_WALK;
					walk_load   = 1'b1;
					tbl_raddr_a = n_q;
				end
			end
			ST_WALK: begin
				if (walk_done) begin
					state_d        = ST_EMIT;
					emit_cmd.start = 1'b1;
				end else begin
					tbl_raddr_a = pred_v;
				end
			end
			ST_EMIT: begin
				if (!emit_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_q       <= (AW+1)'(2);
			div3_q      <= '0;
			mod3_q      <= 2'd2;
			last_step_q <= '0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= fill_issue;
			if (fill_issue) begin
				nxt_q <= nxt_q + (AW+1)'(1);
				if (mod3_q == 2'd2) begin
					mod3_q <= 2'd0;
					div3_q <= div3_q + AW'(1);
				end else begin
					mod3_q <= mod3_q + 2'd1;
				end
			end
			if (vld_s1) begin
				last_step_q <= best[STEP_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= n_in;
		end
		if (fill_issue) begin
			i_s1      <= nxt_q[AW-1:0];
			even_s1   <= ~nxt_q[0];
			tri_s1    <= (mod3_q == 2'd0);
			half1_s1  <= (nxt_q[AW:1] == AW'(1));
			third1_s1 <= (div3_q == AW'(1));
		end
		if (walk_load) begin
			v_q     <= walk_v;
			depth_q <= '0;
		end else if (state_q == ST_WALK && !walk_done) begin
			v_q     <= pred_v;
			depth_q <= depth_q + SP_W'(1);
		end
		if (state_q == ST_WALK) begin
			steps_q <= steps_cur;
		end
	end

endmodule

### design/min_ops_path_to_target_top.sv
`timescale 1ns / 1ps

// shortest add-one / double / triple path from 1 to a target
// input channel: in_valid / in_stall with target; a target of zero is taken as one,
// a target above MAX_N is taken as MAX_N
// output channel: out_valid / out_stall, one transaction per value on the path,
// ascending from 1, each carrying total_steps; is_last marks the target itself
// a request first extends the step table from the highest value filled so far up to
// the target, one entry per cycle through the dual-read table memory, then lets the
// fill pipeline drain; targets already covered skip this
// the walk back then reads the table once per path value, and the stack memory is
// read out one value per cycle while out_stall does not hold the output register
// in_stall is high from acceptance until the engine returns to idle after the last stack read is
// issued; the next request may be taken while the final result still sits in the output register
// when out_stall is high the output register holds its transaction and stack reads pause
// after reset only value one counts as filled; the table memories need no clearing
module min_ops_path_to_target_top #(
	parameter int unsigned MAX_N = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [mopt_pkg::VAL_W-1:0]  target,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [mopt_pkg::VAL_W-1:0]  path_value,
	output logic [mopt_pkg::STEP_W-1:0] total_steps,
	output logic                        is_last
);
	import mopt_pkg::*;

	localparam int unsigned AW = $clog2(MAX_N + 1);

	logic             tbl_we;
	logic [AW-1:0]    tbl_waddr;
	entry_t           tbl_wdata;
	logic [AW-1:0]    tbl_raddr_a;
	logic [AW-1:0]    tbl_raddr_b;
	entry_t           tbl_rdata_a;
	entry_t           tbl_rdata_b;
	logic             stk_we;
	logic [SP_W-1:0]  stk_waddr;
	logic [VAL_W-1:0] stk_wdata;
	logic             stk_re;
	logic [SP_W-1:0]  stk_raddr;
	emit_cmd_t        emit_cmd;
	logic             emit_busy;

	mopt_table #(
		.DEPTH (MAX_N + 1)
	) u_table (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (tbl_waddr),
		.wdata   (tbl_wdata),
		.raddr_a (tbl_raddr_a),
		.raddr_b (tbl_raddr_b),
		.rdata_a (tbl_rdata_a),
		.rdata_b (tbl_rdata_b)
	);

	mopt_stack u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (path_value)
	);

	mopt_engine #(
		.MAX_N (MAX_N)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.target      (target),
		.tbl_we      (tbl_we),
		.tbl_waddr   (tbl_waddr),
		.tbl_wdata   (tbl_wdata),
		.tbl_raddr_a (tbl_raddr_a),
		.tbl_raddr_b (tbl_raddr_b),
		.tbl_rdata_a (tbl_rdata_a),
		.tbl_rdata_b (tbl_rdata_b),
		.stk_we      (stk_we),
		.stk_waddr   (stk_waddr),
		.stk_wdata   (stk_wdata),
		.emit_cmd    (emit_cmd),
		.emit_busy   (emit_busy)
	);

	mopt_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (emit_cmd),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.total_steps (total_steps),
		.is_last     (is_last),
		.busy        (emit_busy),
		.stack_re    (stk_re),
		.stack_raddr (stk_raddr)
	);

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import mopt_pkg::*;

	localparam int unsigned MAX_N = 65536;

	localparam logic [VAL_W-1:0] DIRECTED [26] = '{
		17'd1, 17'd0, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9,
		17'd10, 17'd27, 17'd26, 17'd96, 17'd97, 17'd243, 17'd1000, 17'd999,
		17'd2048, 17'd6561, 17'd20000, 17'd59049, 17'd65535, 17'd65536,
		17'd65537, 17'd131071
	};

	typedef struct {
		logic [VAL_W-1:0]  value;
		logic [STEP_W-1:0] steps;
		logic              last;
	} path_item_t;

	class path_checker;
		logic [STEP_W-1:0] step_tbl [0:MAX_N];
		op_t               pred_tbl [0:MAX_N];
		int unsigned       filled;
		path_item_t        expected_path [$];
		int                fails;

		function new();
			filled      = 1;
			step_tbl[1] = '0;
			fails       = 0;
		endfunction

		function int unsigned pending();
			return expected_path.size();
		endfunction

		// extend the tables up to the target, then walk back and queue the path
		function void note_target(logic [VAL_W-1:0] raw);
			int unsigned n;
			int unsigned v;
			int unsigned best;
			int unsigned steps;
			int unsigned walk [$];
			op_t         op;
			path_item_t  item;
			n = raw;
			if (n == 0)
				n = 1;
			if (n > MAX_N)
				n = MAX_N;
			for (int unsigned i = filled + 1; i <= n; i++) begin
				best = step_tbl[i-1] + 1;
				op   = OP_ADD1;
				if ((i % 2) == 0 && step_tbl[i/2] + 1 < best) begin
					best = step_tbl[i/2] + 1;
					op   = OP_DOUBLE;
				end
				if ((i % 3) == 0 && step_tbl[i/3] + 1 < best) begin
					best = step_tbl[i/3] + 1;
					op   = OP_TRIPLE;
				end
				step_tbl[i] = STEP_W'(best);
				pred_tbl[i] = op;
			end
			if (n > filled)
				filled = n;
			steps = step_tbl[n];
			v = n;
			while (walk.size() < STACK_DEPTH) begin
				walk = {walk, v};
				if (v <= 1)
					break;
				case (pred_tbl[v])
					OP_DOUBLE: v = v / 2;
					OP_TRIPLE: v = v / 3;
					default:   v = v - 1;
				endcase
			end
			for (int k = walk.size() - 1; k >= 0; k--) begin
				item.value = VAL_W'(walk[k]);
				item.steps = STEP_W'(steps);
				item.last  = (k == 0);
				expected_path = {expected_path, item};
			end
		endfunction

		function void check_result(logic [VAL_W-1:0] value, logic [STEP_W-1:0] steps,
				logic last);
			path_item_t want;
			if (expected_path.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual value %0d steps %0d last %0b",
					$time, value, steps, last);
				fails++;
				return;
			end
			want = expected_path.pop_front();
			if (value !== want.value) begin
				$display("%0t: path_value expected %0d actual %0d", $time, want.value, value);
				fails++;
			end
			if (steps !== want.steps) begin
				$display("%0t: total_steps expected %0d actual %0d", $time, want.steps, steps);
				fails++;
			end
			if (last !== want.last) begin
				$display("%0t: is_last expected %0b actual %0b", $time, want.last, last);
				fails++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [VAL_W-1:0]  target = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [VAL_W-1:0]  path_value;
	logic [STEP_W-1:0] total_steps;
	logic              is_last;

	path_checker sb = new();

	int unsigned out_wait = 0;
	bit          out_quiet = 1'b0;

	min_ops_path_to_target_top #(
		.MAX_N(MAX_N)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.target(target),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.path_value(path_value),
		.total_steps(total_steps),
		.is_last(is_last)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// mostly short paths, some anywhere up to MAX_N, a few zero or saturating
	function automatic logic [VAL_W-1:0] random_target();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;
		else if (pick == 1)
			return VAL_W'($urandom_range(MAX_N + 1, (1 << VAL_W) - 1));
		else if (pick <= 8)
			return VAL_W'($urandom_range(1, 64));
		else if (pick <= 12)
			return VAL_W'($urandom_range(1, 1024));
		else
			return VAL_W'($urandom_range(1, MAX_N));
	endfunction

	// entered and left at a falling edge
	task automatic send_target(logic [VAL_W-1:0] t, int unsigned gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		target   <= t;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_target(t);
		@(negedge clk);
	endtask

	initial begin
		bit quiet;
		quiet = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (DIRECTED[i])
			send_target(DIRECTED[i], $urandom_range(0, 17));
		for (int i = 0; i < 154; i++) begin
			if ($urandom_range(0, 15) == 0)
				quiet = !quiet;
			send_target(random_target(), quiet ? 0 : $urandom_range(0, 17));
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// result side: check each transaction, then hold off for a drawn number of cycles
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(path_value, total_steps, is_last);
			if ($urandom_range(0, 15) == 0)
				out_quiet = !out_quiet;
			out_wait = out_quiet ? 0 : $urandom_range(0, 17);
		end
	end

	always @(negedge clk) begin
		out_stall <= (out_wait != 0);
		if (out_wait != 0)
			out_wait = out_wait - 1;
	end

endmodule

### min_ops_path_to_target_top.f
design/mopt_pkg.sv
design/mopt_table.sv
design/mopt_stack.sv
design/mopt_emit.sv
design/mopt_engine.sv
design/min_ops_path_to_target_top.sv
tb/sv/tb.sv
